>>> hdl/nlsp_pkg.sv
// Shared constants and types for the NFDH level strip placer.
package nlsp_pkg;

   // Register port geometry: two 32-bit registers at byte addresses 0 and 4
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_SEL_BIT   = 2;

   // Register index as decoded from the word address
   typedef enum logic [0:0] {
      CSR_SHEET_WIDTH  = 1'b0,
      CSR_SHEET_HEIGHT = 1'b1
   } csr_reg_type;

endpackage

>>> hdl/nlsp_req_if.sv
// Input channel of the placer: one rectangle per beat.
interface nlsp_req_if #(parameter int DIM_BITS = 16);
   logic                valid;
   logic                ready;
   logic [DIM_BITS-1:0] item_width;
   logic [DIM_BITS-1:0] item_height;
   logic                sheet_start;

   modport source (output valid, output item_width, output item_height,
                   output sheet_start, input ready);
   modport sink (input valid, input item_width, input item_height,
                 input sheet_start, output ready);
endinterface

>>> hdl/nlsp_rsp_if.sv
// Result channel of the placer: one placement decision per beat.
interface nlsp_rsp_if #(parameter int DIM_BITS = 16);
   logic                valid;
   logic                ready;
   logic                placed;
   logic [DIM_BITS-1:0] pos_x;
   logic [DIM_BITS-1:0] pos_y;
   logic                turned;
   logic                level_opened;

   modport source (output valid, output placed, output pos_x, output pos_y,
                   output turned, output level_opened, input ready);
   modport sink (input valid, input placed, input pos_x, input pos_y,
                 input turned, input level_opened, output ready);
endinterface

>>> hdl/nfdh_level_strip_placer.sv
// A rectangle passes the input register and then the result register before its result beat shows.
// Throughput: one rectangle per cycle unless the result side stalls; the fit
//   decision and level update sit between input and result registers; the level
//   state is written in the same cycle; the next one sees it without a bubble.
// Reset (synchronous, active high) clears both valid flags, the level state
//   and the sheet size registers.
module nfdh_level_strip_placer #(
   parameter int DIM_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   nlsp_req_if.sink                            req_bus,
   nlsp_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nlsp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [nlsp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [nlsp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

   // Sheet size registers
   logic [DIM_BITS-1:0] sheet_w_ff, sheet_h_ff;
   nlsp_pkg::csr_reg_type csr_sel;
   logic csr_wr;

   // Input stage
   logic                s1_v_ff, s1_v_in;
   logic [DIM_BITS-1:0] s1_w_ff, s1_h_ff;
   logic                s1_start_ff;
   logic                s1_go;

   // Level state
   logic [DIM_BITS-1:0] lvl_x_ff, lvl_y_ff, lvl_h_ff, lvl_room_ff;
   logic [DIM_BITS-1:0] lvl_x_in, lvl_y_in, lvl_h_in, lvl_room_in;

   // Result stage
   logic                out_v_ff, out_v_in;
   logic                out_placed_ff, out_placed_in;
   logic [DIM_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                out_turned_ff, out_turned_in;
   logic                out_opened_ff, out_opened_in;

   // Register port: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = nlsp_pkg::csr_reg_type'(csr_paddr[nlsp_pkg::CSR_SEL_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sheet_w_ff <= '0;
         sheet_h_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            nlsp_pkg::CSR_SHEET_WIDTH:  sheet_w_ff <= csr_pwdata[DIM_BITS-1:0];
            nlsp_pkg::CSR_SHEET_HEIGHT: sheet_h_ff <= csr_pwdata[DIM_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         nlsp_pkg::CSR_SHEET_WIDTH:
            csr_prdata = nlsp_pkg::CSR_DATA_BITS'(sheet_w_ff);
         nlsp_pkg::CSR_SHEET_HEIGHT:
            csr_prdata = nlsp_pkg::CSR_DATA_BITS'(sheet_h_ff);
      endcase
   end

   // Pipeline flow: result register frees up, input stage moves forward
   assign s1_go         = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_v_ff || s1_go;
   assign s1_v_in       = req_bus.ready ? req_bus.valid : s1_v_ff;
   assign out_v_in      = s1_go ? s1_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_w_ff     <= req_bus.item_width;
         s1_h_ff     <= req_bus.item_height;
         s1_start_ff <= req_bus.sheet_start;
      end
   end

   // Fit decision: current level, then one freshly opened level
   always_comb begin
      logic [DIM_BITS-1:0] b_x, b_y, b_h, b_room;
      logic [DIM_BITS:0]   x_sum, y_sum;
      logic [DIM_BITS-1:0] n_y, n_h;
      logic                fit_a, fit_b, fit_c, fit_d;
      logic [DIM_BITS-1:0] pw, ph;

      // Starting state, optionally reset to an empty level at the origin
      if (s1_start_ff) begin
         b_x    = '0;
         b_y    = '0;
         b_h    = sheet_h_ff;
         b_room = sheet_w_ff;
      end else begin
         b_x    = lvl_x_ff;
         b_y    = lvl_y_ff;
         b_h    = lvl_h_ff;
         b_room = lvl_room_ff;
      end

      fit_a = (s1_w_ff <= b_room) && (s1_h_ff <= b_h);
      fit_b = (s1_h_ff <= b_room) && (s1_w_ff <= b_h);

      // Next level above the current one, y saturated at the top code
      y_sum = {1'b0, b_y} + {1'b0, b_h};
      n_y   = y_sum[DIM_BITS] ? DIM_MAX : y_sum[DIM_BITS-1:0];
      n_h   = (n_y > sheet_h_ff) ? '0 : sheet_h_ff - n_y;
      fit_c = (s1_w_ff <= sheet_w_ff) && (s1_h_ff <= n_h);
      fit_d = (s1_h_ff <= sheet_w_ff) && (s1_w_ff <= n_h);

      out_placed_in = 1'b0;
      out_x_in      = '0;
      out_y_in      = '0;
      out_turned_in = 1'b0;
      out_opened_in = 1'b0;
      lvl_x_in      = b_x;
      lvl_y_in      = b_y;
      lvl_h_in      = b_h;
      lvl_room_in   = b_room;

      if (fit_a || fit_b) begin
         pw            = fit_a ? s1_w_ff : s1_h_ff;
         ph            = fit_a ? s1_h_ff : s1_w_ff;
         out_placed_in = 1'b1;
         out_turned_in = !fit_a;
         out_x_in      = b_x;
         out_y_in      = b_y;
         x_sum         = {1'b0, b_x} + {1'b0, pw};
         lvl_x_in      = x_sum[DIM_BITS] ? DIM_MAX : x_sum[DIM_BITS-1:0];
         lvl_room_in   = b_room - pw;
         if (b_x == '0) begin
            lvl_h_in = ph;
         end
      end else begin
         pw    = fit_c ? s1_w_ff : s1_h_ff;
         ph    = fit_c ? s1_h_ff : s1_w_ff;
         x_sum = '0;
         // Only a level that holds something is closed
         if (b_x != '0) begin
            out_opened_in = 1'b1;
            lvl_x_in      = '0;
            lvl_y_in      = n_y;
            lvl_h_in      = n_h;
            lvl_room_in   = sheet_w_ff;
            if (fit_c || fit_d) begin
               out_placed_in = 1'b1;
               out_turned_in = !fit_c;
               out_y_in      = n_y;
               lvl_x_in      = pw;
               lvl_h_in      = ph;
               lvl_room_in   = sheet_w_ff - pw;
            end
         end
      end
   end

   // Level state advances with each item that leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_x_ff    <= '0;
         lvl_y_ff    <= '0;
         lvl_h_ff    <= '0;
         lvl_room_ff <= '0;
      end else if (s1_v_ff && s1_go) begin
         lvl_x_ff    <= lvl_x_in;
         lvl_y_ff    <= lvl_y_in;
         lvl_h_ff    <= lvl_h_in;
         lvl_room_ff <= lvl_room_in;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (s1_v_ff && s1_go) begin
         out_placed_ff <= out_placed_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_turned_ff <= out_turned_in;
         out_opened_ff <= out_opened_in;
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.placed       = out_placed_ff;
   assign rsp_bus.pos_x        = out_x_ff;
   assign rsp_bus.pos_y        = out_y_ff;
   assign rsp_bus.turned       = out_turned_ff;
   assign rsp_bus.level_opened = out_opened_ff;

endmodule

>>> hdl/nlsp_checker.sv
// Port-level assertions for the placer, bound to the top level.
module nlsp_checker #(
   parameter int DIM_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_placed,
   input logic [DIM_BITS-1:0] rsp_pos_x,
   input logic [DIM_BITS-1:0] rsp_pos_y,
   input logic                rsp_turned,
   input logic                rsp_level_opened
);

   // No result beat right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // A rejected rectangle reports an all-zero placement
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_placed) |-> (rsp_pos_x == '0 && rsp_pos_y == '0 && !rsp_turned))
      else $error("rejected beat carries a placement");

   // A rectangle placed on a newly opened level sits at its left edge
   a_open_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_placed && rsp_level_opened) |-> (rsp_pos_x == '0))
      else $error("rectangle on new level not at x zero");

   // A stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_placed) &&
         $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_turned) &&
         $stable(rsp_level_opened)))
      else $error("stalled result beat changed");

endmodule

bind nfdh_level_strip_placer nlsp_checker #(.DIM_BITS(DIM_BITS)) u_nlsp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_placed       (rsp_bus.placed),
   .rsp_pos_x        (rsp_bus.pos_x),
   .rsp_pos_y        (rsp_bus.pos_y),
   .rsp_turned       (rsp_bus.turned),
   .rsp_level_opened (rsp_bus.level_opened)
);

>>> tb/sv/nlsp_checker.sv
// Placement checker: tracks sheet registers, predicts each rectangle's result and compares beats.
module nlsp_place_scoreboard #(
   parameter int DIM_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   nlsp_req_if                                 req_mon,
   nlsp_rsp_if                                 rsp_mon,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nlsp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [nlsp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count,
   output int unsigned                         rect_count,
   output int unsigned                         placed_count,
   output int unsigned                         turned_count,
   output int unsigned                         opened_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [DIM_BITS-1:0] dim_type;

   typedef struct packed {
      logic    placed;
      dim_type pos_x;
      dim_type pos_y;
      logic    turned;
      logic    level_opened;
   } placement_type;

   // Shadow of the sheet registers and of the current level
   dim_type sheet_w, sheet_h;
   dim_type lvl_x, lvl_y, lvl_height, lvl_room;

   placement_type placements_due[$];
   int unsigned beats_seen;

   // One orientation on the current level; updates the level when it fits
   function automatic bit try_orient(input dim_type w, input dim_type h, input logic turn,
                                     inout placement_type r);
      logic [DIM_BITS:0] next_x;
      if (w > lvl_room || h > lvl_height)
         return 1'b0;
      r.placed = 1'b1;
      r.pos_x  = lvl_x;
      r.pos_y  = lvl_y;
      r.turned = turn;
      // first rectangle on an empty level sets its height
      if (lvl_x == '0)
         lvl_height = h;
      next_x = {1'b0, lvl_x} + w;
      lvl_x = next_x[DIM_BITS] ? '1 : next_x[DIM_BITS-1:0];
      lvl_room = lvl_room - w;
      return 1'b1;
   endfunction

   function automatic bit fit_either(input dim_type w, input dim_type h,
                                     inout placement_type r);
      if (try_orient(w, h, 1'b0, r))
         return 1'b1;
      return try_orient(h, w, 1'b1, r);
   endfunction

   function automatic placement_type predict_placement(input dim_type w, input dim_type h,
                                                       input logic start);
      placement_type r;
      logic [DIM_BITS:0] next_y;
      r = '0;
      if (start) begin
         lvl_x      = '0;
         lvl_y      = '0;
         lvl_height = sheet_h;
         lvl_room   = sheet_w;
      end
      // no fit: open a level above, unless the current one is still empty
      if (!fit_either(w, h, r) && lvl_x != '0) begin
         next_y     = {1'b0, lvl_y} + lvl_height;
         lvl_y      = next_y[DIM_BITS] ? '1 : next_y[DIM_BITS-1:0];
         lvl_x      = '0;
         lvl_height = (lvl_y > sheet_h) ? '0 : dim_type'(sheet_h - lvl_y);
         lvl_room   = sheet_w;
         r.level_opened = 1'b1;
         void'(fit_either(w, h, r));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("[%0t] result beat %0d: %s is %0h, expected %0h",
               $time, beats_seen, what, got, want);
   endtask

   always @(posedge clock) begin : monitor
      placement_type want;
      placement_type got;
      if (reset) begin
         sheet_w = '0;
         sheet_h = '0;
         lvl_x = '0;
         lvl_y = '0;
         lvl_height = '0;
         lvl_room = '0;
         placements_due.delete();
         beats_seen = 0;
         fail_count = 0;
         rect_count = 0;
         placed_count = 0;
         turned_count = 0;
         opened_count = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (nlsp_pkg::csr_reg_type'(csr_paddr[nlsp_pkg::CSR_SEL_BIT]))
               nlsp_pkg::CSR_SHEET_WIDTH:  sheet_w = csr_pwdata[DIM_BITS-1:0];
               nlsp_pkg::CSR_SHEET_HEIGHT: sheet_h = csr_pwdata[DIM_BITS-1:0];
               default: ;
            endcase
         end
         // result beats against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            beats_seen++;
            if (placements_due.size() == 0) begin
               report_mismatch("beat with nothing expected, placed", rsp_mon.placed, 0);
            end else begin
               want = placements_due.pop_front();
               got.placed       = rsp_mon.placed;
               got.pos_x        = rsp_mon.pos_x;
               got.pos_y        = rsp_mon.pos_y;
               got.turned       = rsp_mon.turned;
               got.level_opened = rsp_mon.level_opened;
               if (got.placed !== want.placed)
                  report_mismatch("placed", got.placed, want.placed);
               if (got.pos_x !== want.pos_x)
                  report_mismatch("pos_x", got.pos_x, want.pos_x);
               if (got.pos_y !== want.pos_y)
                  report_mismatch("pos_y", got.pos_y, want.pos_y);
               if (got.turned !== want.turned)
                  report_mismatch("turned", got.turned, want.turned);
               if (got.level_opened !== want.level_opened)
                  report_mismatch("level_opened", got.level_opened, want.level_opened);
            end
         end
         // rectangle beats
         if (req_mon.valid && req_mon.ready) begin
            want = predict_placement(req_mon.item_width, req_mon.item_height,
                                     req_mon.sheet_start);
            placements_due.push_back(want);
            rect_count++;
            if (want.placed)       placed_count++;
            if (want.turned)       turned_count++;
            if (want.level_opened) opened_count++;
         end
      end
      pending_count <= placements_due.size();
   end

endmodule

>>> tb/sv/testbench.sv
// Bench top for the level strip placer: clock, reset, register writes, rectangles, verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_BITS = 16;
   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned PHASE_RECTS = 75;

   logic clock;
   logic reset;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [nlsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [nlsp_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [nlsp_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   nlsp_req_if #(.DIM_BITS(DIM_BITS)) req_bus ();
   nlsp_rsp_if #(.DIM_BITS(DIM_BITS)) rsp_bus ();

   int unsigned fail_count, pending_count, rect_count;
   int unsigned placed_count, turned_count, opened_count;
   int unsigned sheet_settings;
   int unsigned cycle_count;
   int unsigned cur_w, cur_h;
   bit   steady;
   logic rsp_fire = 1'b0;

   nfdh_level_strip_placer #(.DIM_BITS(DIM_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   nlsp_place_scoreboard #(.DIM_BITS(DIM_BITS)) place_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rect_count    (rect_count),
      .placed_count  (placed_count),
      .turned_count  (turned_count),
      .opened_count  (opened_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // Result side: after each beat, hold ready low for a random stall, none when steady
   always @(posedge clock) rsp_fire <= rsp_bus.valid && rsp_bus.ready;

   initial begin : result_ready
      int unsigned hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_fire)
            hold = steady ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // One rectangle beat; called and returns at a falling edge
   task automatic send_rect(input int unsigned w, input int unsigned h, input bit start);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.item_width  <= DIM_BITS'(w);
      req_bus.item_height <= DIM_BITS'(h);
      req_bus.sheet_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // APB write: setup phase, then access phase, then back to idle
   task automatic csr_write(input nlsp_pkg::csr_reg_type which,
                            input logic [DIM_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= nlsp_pkg::CSR_ADDR_BITS'(which) << nlsp_pkg::CSR_SEL_BIT;
      csr_pwdata  <= {(nlsp_pkg::CSR_DATA_BITS-DIM_BITS)'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_sheet(input int unsigned w, input int unsigned h);
      wait_drain();
      csr_write(nlsp_pkg::CSR_SHEET_WIDTH, DIM_BITS'(w));
      csr_write(nlsp_pkg::CSR_SHEET_HEIGHT, DIM_BITS'(h));
      cur_w = w;
      cur_h = h;
      sheet_settings++;
   endtask

   // A sheet's worth of rectangles in non-increasing height, random widths, some swapped
   task automatic run_sheet(input int unsigned count, inout int unsigned sent);
      int unsigned h_cur, h_top, w;
      bit start;
      h_top = cur_h + cur_h / 8 + 1;
      if (h_top > 65535) h_top = 65535;
      h_cur = $urandom_range(0, h_top);
      // now and then the sheet is not restarted, so the old levels carry on
      start = ($urandom_range(0, 7) != 0);
      for (int unsigned k = 0; k < count; k++) begin
         w = $urandom_range(0, cur_w / 3 + 1);
         if ($urandom_range(0, 4) == 0)
            send_rect(h_cur, w, start && k == 0);
         else
            send_rect(w, h_cur, start && k == 0);
         sent++;
         h_cur = h_cur - $urandom_range(0, h_cur / 3);
      end
   endtask

   // Unordered rectangles over the full field range
   task automatic run_noise(input int unsigned count, inout int unsigned sent);
      int unsigned w, h;
      for (int unsigned k = 0; k < count; k++) begin
         w = $urandom_range(0, 65535);
         h = $urandom_range(0, 65535);
         if ($urandom_range(0, 1) == 0) w = w % (cur_w + 2);
         if ($urandom_range(0, 1) == 0) h = h % (cur_h + 2);
         send_rect(w, h, $urandom_range(0, 3) == 0);
         sent++;
      end
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h);
      int unsigned sent;
      sent = 0;
      set_sheet(w, h);
      while (sent < PHASE_RECTS) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8)
            run_sheet($urandom_range(1, 20), sent);
         else
            run_noise($urandom_range(1, 5), sent);
         // occasionally hold off until everything is back
         if ($urandom_range(0, 9) == 0)
            wait_drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.item_width  = '0;
      req_bus.item_height = '0;
      req_bus.sheet_start = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      steady              = 1'b0;
      sheet_settings      = 0;
      cur_w               = 0;
      cur_h               = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state used as it stands, zero-size sheet
      send_rect(0, 0, 1'b0);
      send_rect(5, 5, 1'b0);
      send_rect(0, 0, 1'b1);

      // Small sheet: level fill, new level, rotation, zero width, rejection
      set_sheet(100, 60);
      send_rect(30, 20, 1'b1);
      send_rect(70, 20, 1'b0);
      send_rect(20, 10, 1'b0);
      send_rect(10, 30, 1'b0);
      send_rect(0, 5, 1'b0);
      send_rect(90, 50, 1'b0);
      // zero width leaves x at zero, so a later rectangle that fits sets the level height again
      send_rect(0, 40, 1'b1);
      send_rect(50, 50, 1'b0);
      send_rect(50, 30, 1'b0);

      // Largest sheet: full-size rectangle, level at the top edge
      set_sheet(65535, 65535);
      send_rect(65535, 65535, 1'b1);
      send_rect(65535, 0, 1'b0);
      send_rect(0, 0, 1'b0);
      send_rect(1, 1, 1'b0);
      send_rect(0, 0, 1'b0);
      send_rect(65535, 65535, 1'b0);

      // Random part over several sheet sizes, extremes first
      run_phase(65535, 65535);
      run_phase(1, 65535);
      run_phase(65535, 1);
      run_phase(0, 0);
      run_phase($urandom_range(16, 4000), $urandom_range(16, 4000));
      run_phase($urandom_range(16, 4000), $urandom_range(16, 4000));
      run_phase($urandom_range(1, 300), $urandom_range(1, 300));
      run_phase($urandom_range(0, 65535), $urandom_range(0, 65535));

      wait_drain();
      $display("Sent %0d rectangles over %0d sheet sizes: %0d placed, %0d rejected.",
               rect_count, sheet_settings, placed_count, rect_count - placed_count);
      $display("Of those, %0d went on rotated and %0d caused a new level.",
               turned_count, opened_count);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> files.f
hdl/nlsp_pkg.sv
hdl/nlsp_req_if.sv
hdl/nlsp_rsp_if.sv
hdl/nfdh_level_strip_placer.sv
hdl/nlsp_checker.sv
tb/sv/nlsp_checker.sv
tb/sv/testbench.sv
